/* hdl/i3p_pkg.sv */
`timescale 1ns / 1ps
package i3p_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       tag_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  tag_version;
    logic [3:0]  frame_code;
    logic [27:0] frame_size;
    logic [7:0]  text_encoding;
    logic        encoding_present;
    logic [7:0]  payload_byte;
    logic        end_of_frame;
    logic        end_of_tag;
    logic [2:0]  error_code;
  } out_item_t;

  // event kinds
  localparam logic [2:0] EV_HEADER  = 3'd0;
  localparam logic [2:0] EV_FRAME   = 3'd1;
  localparam logic [2:0] EV_PAYLOAD = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;
  localparam logic [2:0] EV_NOT_ID3 = 3'd5;

  // error codes
  localparam logic [2:0] ERR_VERSION   = 3'd0;
  localparam logic [2:0] ERR_HDR_FLAGS = 3'd1;
  localparam logic [2:0] ERR_TOO_SMALL = 3'd2;
  localparam logic [2:0] ERR_FR_FLAGS  = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

  // dense frame codes
  localparam logic [3:0] FC_UNKNOWN   = 4'd0;
  localparam logic [3:0] FC_PICTURE   = 4'd1;
  localparam logic [3:0] FC_COMMENT   = 4'd2;
  localparam logic [3:0] FC_ALBUM     = 4'd3;
  localparam logic [3:0] FC_GENRE     = 4'd4;
  localparam logic [3:0] FC_TITLE     = 4'd5;
  localparam logic [3:0] FC_LENGTH    = 4'd6;
  localparam logic [3:0] FC_ARTIST    = 4'd7;
  localparam logic [3:0] FC_ALBUMART  = 4'd8;
  localparam logic [3:0] FC_PUBLISHER = 4'd9;
  localparam logic [3:0] FC_TRACK     = 4'd10;
  localparam logic [3:0] FC_DATE      = 4'd11;

  function automatic logic [3:0] frame_code_of(input logic [2:0] ver,
                                               input logic [31:0] id);
    logic [3:0] code;
    code = FC_UNKNOWN;
    if (ver == 3'd2) begin
      case (id[31:8])
        "COM":   code = FC_COMMENT;
        "PIC":   code = FC_PICTURE;
        "TAL":   code = FC_ALBUM;
        "TCO":   code = FC_GENRE;
        "TLE":   code = FC_LENGTH;
        "TP1":   code = FC_ARTIST;
        "TRK":   code = FC_TRACK;
        "TT2":   code = FC_TITLE;
        "TYE":   code = FC_DATE;
        default: code = FC_UNKNOWN;
      endcase
    end else begin
      case (id)
        "APIC":  code = FC_PICTURE;
        "COMM":  code = FC_COMMENT;
        "TALB":  code = FC_ALBUM;
        "TCON":  code = FC_GENRE;
        "TIT2":  code = FC_TITLE;
        "TLEN":  code = FC_LENGTH;
        "TPE1":  code = FC_ARTIST;
        "TPE2":  code = FC_ALBUMART;
        "TPUB":  code = FC_PUBLISHER;
        "TRCK":  code = FC_TRACK;
        "TYER":  code = FC_DATE;
        default: code = FC_UNKNOWN;
      endcase
    end
    return code;
  endfunction

endpackage

/* hdl/id3v2_tag_stream_parser.sv */
`timescale 1ns / 1ps
// A byte in the input register gives its item (if any) in the output register
// once that is free. Throughput: one byte per cycle while the output is not
// stalled; the parse state and header bytes update in one pass from input to output register.
// Reset (rst_ni low, asynchronous): parser back in header phase, both
// registers empty. tag_start on a byte restarts the parser as well.
module id3v2_tag_stream_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i3p_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i3p_pkg::out_item_t out_data_o
);
  import i3p_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_free;
  logic      fire;
  logic      res_valid;
  out_item_t res;

  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
  end

  i3p_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  i3p_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/i3p_core.sv */
`timescale 1ns / 1ps
module i3p_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  i3p_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output i3p_pkg::out_item_t res_o
);
  import i3p_pkg::*;

  localparam logic [3:0] PH_HEADER   = 4'd0;
  localparam logic [3:0] PH_IDLE     = 4'd1;
  localparam logic [3:0] PH_EXT_SIZE = 4'd2;
  localparam logic [3:0] PH_EXT_DATA = 4'd3;
  localparam logic [3:0] PH_FRAME    = 4'd4;
  localparam logic [3:0] PH_DATALEN  = 4'd5;
  localparam logic [3:0] PH_TXTENC   = 4'd6;
  localparam logic [3:0] PH_DATA     = 4'd7;
  localparam logic [3:0] PH_SKIP     = 4'd8;
  localparam logic [3:0] PH_FINISHED = 4'd9;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  cnt;
    logic [27:0] tag_left;
    logic [27:0] frame_left;
    logic [31:0] skip_left;
    logic [2:0]  major;
    logic        tag_unsync;
    logic [7:0]  flag_byte;
    logic [3:0]  cur_frame;
    logic [7:0]  enc;
    logic        after_ff;
    logic        text_frame;
  } state_t;

  localparam state_t ST_RESET = '{phase: PH_HEADER, default: '0};

  state_t     s_q, s_d, s;
  logic [7:0] hb_q [10];
  logic [7:0] hbv  [10];
  logic       hb_we;
  logic [3:0] hb_idx;
  logic [7:0] b;
  logic [27:0] left_prev, tl;
  logic [3:0] hl;
  logic [31:0] size;
  logic [27:0] hsize;
  logic [27:0] fl_new;
  logic [3:0] cnt_inc;
  logic [3:0] code;
  logic [7:0] fl1;
  logic       unsync;
  logic       active;
  logic       have;
  out_item_t  r;

  always_comb begin
    s      = item_i.tag_start ? ST_RESET : s_q;
    b      = item_i.byte_in;
    left_prev = s.tag_left;
    tl     = left_prev - 28'd1;
    hl     = (s.major == 3'd2) ? 4'd6 : 4'd10;
    cnt_inc = s.cnt + 4'd1;
    hb_we  = 1'b0;
    if (s.cnt < 4'd10) begin
      if (s.phase == PH_HEADER) begin
        hb_we = 1'b1;
      end else if (s.phase == PH_FRAME &&
                   !(s.cnt == 4'd0 && (b == 8'd0 || left_prev < 28'(hl)))) begin
        hb_we = 1'b1;
      end
    end
    hb_idx = s.cnt;
    for (int i = 0; i < 10; i++) begin
      hbv[i] = (hb_we && hb_idx == 4'(i)) ? b : hb_q[i];
    end

    hsize = {hbv[6][6:0], hbv[7][6:0], hbv[8][6:0], hbv[9][6:0]};
    case (s.major)
      3'd2:    size = {8'd0, hbv[3], hbv[4], hbv[5]};
      3'd3:    size = {hbv[4], hbv[5], hbv[6], hbv[7]};
      default: size = {4'd0, hbv[4][6:0], hbv[5][6:0], hbv[6][6:0], hbv[7][6:0]};
    endcase
    fl1    = (s.major == 3'd2) ? 8'd0 : hbv[9];
    code   = frame_code_of(s.major, {hbv[0], hbv[1], hbv[2], hbv[3]});
    unsync = s.tag_unsync || (s.major == 3'd4 && s.flag_byte[1]);
    fl_new = (s.frame_left != 28'd0) ? s.frame_left - 28'd1 : 28'd0;

    s_d    = s;
    have   = 1'b0;
    r      = '0;
    active = !(s.phase == PH_IDLE || s.phase >= PH_FINISHED);

    if (s.phase == PH_HEADER) begin
      s_d.cnt = cnt_inc;
      if (s.cnt >= 4'd9) begin
        s_d.cnt = 4'd0;
        have    = 1'b1;
        if (hbv[0] != 8'h49 || hbv[1] != 8'h44 || hbv[2] != 8'h33 ||
            hbv[3] == 8'hFF || hbv[4] == 8'hFF ||
            ((hbv[6] | hbv[7] | hbv[8] | hbv[9]) & 8'h80) != 8'd0) begin
          s_d.phase    = PH_IDLE;
          r.event_kind = EV_NOT_ID3;
        end else begin
          s_d.tag_left = hsize;
          s_d.phase    = PH_SKIP;
          if (hbv[3] < 8'd2 || hbv[3] > 8'd4) begin
            r.event_kind = EV_ERROR;
            r.error_code = ERR_VERSION;
          end else begin
            s_d.major     = hbv[3][2:0];
            r.tag_version = hbv[3][2:0];
            if ((hbv[3] == 8'd3 && hbv[5][5:0] != 6'd0) ||
                (hbv[3] != 8'd3 && hbv[5][6:0] != 7'd0)) begin
              r.event_kind = EV_ERROR;
              r.error_code = ERR_HDR_FLAGS;
            end else begin
              s_d.tag_unsync = hbv[5][7];
              s_d.skip_left  = '0;
              r.event_kind   = EV_HEADER;
              s_d.phase      = (hbv[3] == 8'd3 && hbv[5][6]) ? PH_EXT_SIZE : PH_FRAME;
            end
          end
          if (hsize == 28'd0) begin
            s_d.phase    = PH_FINISHED;
            r.end_of_tag = 1'b1;
          end
        end
      end
    end else if (active) begin
      s_d.tag_left  = tl;
      r.tag_version = s.major;
      case (s.phase)
        PH_EXT_SIZE: begin
          if (s.cnt == 4'd0 && left_prev < 28'd4) begin
            have = 1'b1; r.event_kind = EV_ERROR; r.error_code = ERR_TOO_SMALL;
            s_d.phase = PH_SKIP;
          end else begin
            s_d.skip_left = {s.skip_left[23:0], b};
            s_d.cnt       = cnt_inc;
            if (cnt_inc >= 4'd4) begin
              s_d.cnt   = 4'd0;
              s_d.phase = (s_d.skip_left != 32'd0) ? PH_EXT_DATA : PH_FRAME;
            end
          end
        end
        PH_EXT_DATA: begin
          if (s.cnt == 4'd0 && {4'd0, left_prev} < s.skip_left) begin
            have = 1'b1; r.event_kind = EV_ERROR; r.error_code = ERR_TOO_SMALL;
            s_d.phase = PH_SKIP;
          end else begin
            s_d.cnt       = 4'd1;
            s_d.skip_left = s.skip_left - 32'd1;
            if (s_d.skip_left == 32'd0) begin
              s_d.cnt   = 4'd0;
              s_d.phase = PH_FRAME;
            end
          end
        end
        PH_FRAME: begin
          if (s.cnt == 4'd0 && b == 8'd0) begin
            s_d.phase = PH_SKIP;                  // padding
          end else if (s.cnt == 4'd0 && left_prev < 28'(hl)) begin
            have = 1'b1; r.event_kind = EV_ERROR; r.error_code = ERR_TOO_SMALL;
            s_d.phase = PH_SKIP;
          end else begin
            s_d.cnt = cnt_inc;
            if (cnt_inc >= hl) begin
              s_d.cnt = 4'd0;
              have    = 1'b1;
              if (size > {4'd0, tl}) begin
                r.event_kind = EV_ERROR; r.error_code = ERR_TOO_LARGE;
                s_d.phase = PH_SKIP;
              end else if ((s.major == 3'd4 && fl1[7:2] != 6'd0) ||
                           (s.major != 3'd4 && fl1 != 8'd0)) begin
                r.event_kind = EV_ERROR; r.error_code = ERR_FR_FLAGS;
                s_d.phase = PH_SKIP;
              end else begin
                s_d.cur_frame  = code;
                s_d.flag_byte  = fl1;
                s_d.text_frame = (hbv[0] == 8'h54) || (code == FC_COMMENT);
                s_d.enc        = 8'd0;
                s_d.after_ff   = 1'b0;
                s_d.frame_left = size[27:0];
                r.event_kind   = EV_FRAME;
                r.frame_code   = code;
                r.frame_size   = size[27:0];
                r.encoding_present = s_d.text_frame;
                if (s.major == 3'd4 && fl1[0]) begin
                  s_d.phase = PH_DATALEN;
                end else if (size == 32'd0) begin
                  s_d.phase = PH_FRAME;
                end else begin
                  s_d.phase = s_d.text_frame ? PH_TXTENC : PH_DATA;
                end
              end
            end
          end
        end
        PH_DATALEN: begin
          if (s.cnt == 4'd0 && left_prev < 28'd4) begin
            have = 1'b1; r.event_kind = EV_ERROR; r.error_code = ERR_TOO_SMALL;
            s_d.phase = PH_SKIP;
          end else begin
            s_d.cnt = cnt_inc;
            if (cnt_inc >= 4'd4) begin
              s_d.cnt = 4'd0;
              s_d.frame_left = (s.frame_left >= 28'd4) ? s.frame_left - 28'd4 : 28'd0;
              if (s_d.frame_left == 28'd0) begin
                s_d.phase = PH_FRAME;
              end else begin
                s_d.phase = s.text_frame ? PH_TXTENC : PH_DATA;
              end
            end
          end
        end
        PH_TXTENC: begin
          s_d.enc        = b;
          s_d.frame_left = fl_new;
          s_d.phase      = (fl_new != 28'd0) ? PH_DATA : PH_FRAME;
        end
        PH_DATA: begin
          s_d.frame_left = fl_new;
          if (s.after_ff && b == 8'd0) begin
            s_d.after_ff = 1'b0;                  // stuffed zero dropped
          end else begin
            s_d.after_ff = unsync && b == 8'hFF;
            have = 1'b1;
            r.event_kind       = EV_PAYLOAD;
            r.frame_code       = s.cur_frame;
            r.text_encoding    = s.text_frame ? s.enc : 8'd0;
            r.encoding_present = s.text_frame;
            r.payload_byte     = b;
            r.end_of_frame     = (fl_new == 28'd0);
          end
          if (fl_new == 28'd0) begin
            s_d.phase = PH_FRAME;
          end
        end
        default: begin
        end
      endcase
      if (tl == 28'd0) begin
        s_d.phase    = PH_FINISHED;
        r.end_of_tag = 1'b1;
        if (!have) begin
          have = 1'b1;
          r.event_kind = EV_DONE;
        end
      end
    end
    res_valid_o = fire_i && have;
    res_o       = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= ST_RESET;
    end else if (fire_i) begin
      s_q <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && hb_we) begin
      hb_q[hb_idx] <= b;
    end
  end

endmodule

/* hdl/i3p_out_reg.sv */
`timescale 1ns / 1ps
module i3p_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               res_valid_i,
  input  i3p_pkg::out_item_t res_i,
  input  logic               out_stall_i,
  output logic               free_o,
  output logic               out_valid_o,
  output i3p_pkg::out_item_t out_data_o
);
  import i3p_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* hdl/i3p_checker.sv */
`timescale 1ns / 1ps
module i3p_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input i3p_pkg::out_item_t out_data_o,
  input logic               out_valid_o,
  input logic               out_stall_i
);
  import i3p_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled item changed");

  a_eof_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_frame |-> out_data_o.event_kind == EV_PAYLOAD)
    else $error("end of frame outside payload");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind != EV_ERROR |-> out_data_o.error_code == 3'd0)
    else $error("error code on non-error item");

  a_done_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind == EV_DONE |-> out_data_o.end_of_tag)
    else $error("tag done without end of tag");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

endmodule

bind id3v2_tag_stream_parser i3p_checker u_i3p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

/* tb/tb_id3v2_tag_stream_parser.sv */
`timescale 1ns / 1ps
module tb_id3v2_tag_stream_parser;
  import i3p_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int RANDOM_BYTES = 600;

  typedef enum logic [3:0] {
    PH_HEADER, PH_IDLE, PH_EXT_SIZE, PH_EXT_DATA, PH_FRAME,
    PH_DATALEN, PH_TXTENC, PH_DATA, PH_SKIP, PH_FINISHED
  } parse_phase_e;

  class tag_scoreboard;
    out_item_t    event_q[$];
    int           mismatches;
    int           n_events;
    parse_phase_e phase;
    logic [7:0]   hdr [10];
    logic [3:0]   cnt;
    logic [27:0]  tag_left;
    logic [31:0]  frame_left;
    logic [31:0]  skip_left;
    logic [2:0]   major;
    logic         unsync_all;
    logic [7:0]   fr_flags;
    logic [3:0]   cur_code;
    logic [7:0]   enc;
    logic         after_ff;
    logic         is_text;
    logic [31:0]  ids4 [11] = '{"APIC", "COMM", "TALB", "TCON", "TIT2", "TLEN",
                                "TPE1", "TPE2", "TPUB", "TRCK", "TYER"};
    logic [23:0]  ids3 [9] = '{"COM", "PIC", "TAL", "TCO", "TLE", "TP1", "TRK", "TT2", "TYE"};
    logic [3:0]   codes3 [9] = '{FC_COMMENT, FC_PICTURE, FC_ALBUM, FC_GENRE, FC_LENGTH,
                                 FC_ARTIST, FC_TRACK, FC_TITLE, FC_DATE};

    function void restart();
      phase = PH_HEADER;
      foreach (hdr[i]) hdr[i] = '0;
      cnt = 0; tag_left = 0; frame_left = 0; skip_left = 0; major = 0;
      unsync_all = 0; fr_flags = 0; cur_code = 0; enc = 0; after_ff = 0; is_text = 0;
    endfunction

    function logic [3:0] code_of_id();
      logic [3:0] c;
      c = FC_UNKNOWN;
      if (major == 3'd2) begin
        foreach (ids3[i]) if ({hdr[0], hdr[1], hdr[2]} == ids3[i]) c = codes3[i];
      end else begin
        foreach (ids4[i]) if ({hdr[0], hdr[1], hdr[2], hdr[3]} == ids4[i]) c = 4'(i + 1);
      end
      return c;
    endfunction

    function void to_payload();
      if (frame_left == 0) phase = PH_FRAME;
      else phase = is_text ? PH_TXTENC : PH_DATA;
    endfunction

    // advance the parser by one accepted byte, queue the event it causes
    function void note_byte(in_item_t it);
      logic [7:0]  b, ver, fl, fl1;
      logic [31:0] left_prev, size, raw;
      logic [3:0]  hl, code;
      out_item_t   f;
      int          kind;
      b = it.byte_in;
      f = '0;
      kind = -1;
      if (it.tag_start) restart();
      if (phase == PH_IDLE || phase == PH_FINISHED) return;
      if (phase == PH_HEADER) begin
        hdr[cnt] = b;
        cnt++;
        if (cnt < 10) return;
        cnt = 0;
        if (hdr[0] != 8'h49 || hdr[1] != 8'h44 || hdr[2] != 8'h33 || hdr[3] == 8'hff ||
            hdr[4] == 8'hff || ((hdr[6] | hdr[7] | hdr[8] | hdr[9]) & 8'h80) != 0) begin
          phase = PH_IDLE;
          f.event_kind = EV_NOT_ID3;
          event_q.push_back(f);
          return;
        end
        tag_left = {hdr[6][6:0], hdr[7][6:0], hdr[8][6:0], hdr[9][6:0]};
        ver = hdr[3];
        fl = hdr[5];
        phase = PH_SKIP;
        if (ver < 2 || ver > 4) begin
          f.event_kind = EV_ERROR; f.error_code = ERR_VERSION;
        end else begin
          major = ver[2:0];
          f.tag_version = ver[2:0];
          if ((ver == 3 && (fl & 8'h3f) != 0) || (ver != 3 && (fl & 8'h7f) != 0)) begin
            f.event_kind = EV_ERROR; f.error_code = ERR_HDR_FLAGS;
          end else begin
            unsync_all = fl[7];
            skip_left = 0;
            f.event_kind = EV_HEADER;
            phase = (ver == 3 && fl[6]) ? PH_EXT_SIZE : PH_FRAME;
          end
        end
        if (tag_left == 0) begin
          phase = PH_FINISHED;
          f.end_of_tag = 1'b1;
        end
        event_q.push_back(f);
        return;
      end

      left_prev = 32'(tag_left);
      tag_left = tag_left - 28'd1;
      f.tag_version = major;
      case (phase)
        PH_EXT_SIZE: begin
          if (cnt == 0 && left_prev < 4) begin
            kind = EV_ERROR; f.error_code = ERR_TOO_SMALL; phase = PH_SKIP;
          end else begin
            skip_left = (skip_left << 8) | 32'(b);
            cnt++;
            if (cnt >= 4) begin
              cnt = 0;
              phase = (skip_left != 0) ? PH_EXT_DATA : PH_FRAME;
            end
          end
        end
        PH_EXT_DATA: begin
          if (cnt == 0 && left_prev < skip_left) begin
            kind = EV_ERROR; f.error_code = ERR_TOO_SMALL; phase = PH_SKIP;
          end else begin
            cnt = 1;
            skip_left--;
            if (skip_left == 0) begin
              cnt = 0;
              phase = PH_FRAME;
            end
          end
        end
        PH_FRAME: begin
          hl = (major == 3'd2) ? 4'd6 : 4'd10;
          if (cnt == 0 && b == 0) phase = PH_SKIP;
          else if (cnt == 0 && left_prev < 32'(hl)) begin
            kind = EV_ERROR; f.error_code = ERR_TOO_SMALL; phase = PH_SKIP;
          end else begin
            hdr[cnt] = b;
            cnt++;
            if (cnt >= hl) begin
              cnt = 0;
              if (major == 3'd2) begin
                size = {8'h00, hdr[3], hdr[4], hdr[5]};
                fl1 = 0;
              end else begin
                raw = {hdr[4], hdr[5], hdr[6], hdr[7]};
                size = (major == 3'd3) ? raw
                     : {4'h0, raw[30:24], raw[22:16], raw[14:8], raw[6:0]};
                fl1 = hdr[9];
              end
              code = code_of_id();
              if (size > 32'(tag_left)) begin
                kind = EV_ERROR; f.error_code = ERR_TOO_LARGE; phase = PH_SKIP;
              end else if ((major == 3'd4 && (fl1 & 8'hfc) != 0) ||
                           (major != 3'd4 && fl1 != 0)) begin
                kind = EV_ERROR; f.error_code = ERR_FR_FLAGS; phase = PH_SKIP;
              end else begin
                cur_code = code;
                fr_flags = fl1;
                is_text = (hdr[0] == 8'h54) || code == FC_COMMENT;
                enc = 0;
                after_ff = 0;
                frame_left = size;
                kind = EV_FRAME;
                f.frame_code = code;
                f.frame_size = size[27:0];
                f.encoding_present = is_text;
                if (major == 3'd4 && fl1[0]) phase = PH_DATALEN;
                else to_payload();
              end
            end
          end
        end
        PH_DATALEN: begin
          if (cnt == 0 && left_prev < 4) begin
            kind = EV_ERROR; f.error_code = ERR_TOO_SMALL; phase = PH_SKIP;
          end else begin
            cnt++;
            if (cnt >= 4) begin
              cnt = 0;
              frame_left = (frame_left >= 4) ? frame_left - 4 : 0;
              to_payload();
            end
          end
        end
        PH_TXTENC: begin
          enc = b;
          if (frame_left != 0) frame_left--;
          phase = (frame_left != 0) ? PH_DATA : PH_FRAME;
        end
        PH_DATA: begin
          if (frame_left != 0) frame_left--;
          if (after_ff && b == 0) after_ff = 0;  // stuffed zero is dropped
          else begin
            after_ff = (unsync_all || (major == 3'd4 && fr_flags[1])) && b == 8'hff;
            kind = EV_PAYLOAD;
            f.frame_code = cur_code;
            f.text_encoding = is_text ? enc : 8'h00;
            f.encoding_present = is_text;
            f.payload_byte = b;
            f.end_of_frame = (frame_left == 0);
          end
          if (frame_left == 0) phase = PH_FRAME;
        end
        default: ;
      endcase
      if (tag_left == 0) begin
        phase = PH_FINISHED;
        f.end_of_tag = 1'b1;
        if (kind < 0) kind = EV_DONE;
      end
      if (kind < 0) return;
      f.event_kind = 3'(kind);
      event_q.push_back(f);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        mismatches++;
      end
    endfunction

    function void check_event(out_item_t a);
      out_item_t e;
      n_events++;
      if (event_q.size() == 0) begin
        $error("unexpected event, kind %0d", a.event_kind);
        mismatches++;
        return;
      end
      e = event_q.pop_front();
      cmp("event_kind", 32'(e.event_kind), 32'(a.event_kind));
      cmp("tag_version", 32'(e.tag_version), 32'(a.tag_version));
      cmp("frame_code", 32'(e.frame_code), 32'(a.frame_code));
      cmp("frame_size", 32'(e.frame_size), 32'(a.frame_size));
      cmp("text_encoding", 32'(e.text_encoding), 32'(a.text_encoding));
      cmp("encoding_present", 32'(e.encoding_present), 32'(a.encoding_present));
      cmp("payload_byte", 32'(e.payload_byte), 32'(a.payload_byte));
      cmp("end_of_frame", 32'(e.end_of_frame), 32'(a.end_of_frame));
      cmp("end_of_tag", 32'(e.end_of_tag), 32'(a.end_of_tag));
      cmp("error_code", 32'(e.error_code), 32'(a.error_code));
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  tag_scoreboard sb;
  in_item_t      stim_q[$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_left;
  logic          hold_req;
  logic          hold_done;
  int            cycles;
  int            n_bytes;

  id3v2_tag_stream_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: check, then pick next stall; the long hold-off is counted here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_event(out_data);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] rand_data();
    case ($urandom_range(5))
      0: return 8'hff;
      1: return 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_frame(ref logic [7:0] body[$], input int ver);
    logic [31:0] id;
    int          n;
    logic [7:0]  fl;
    string       ids4 [11] = '{"APIC", "COMM", "TALB", "TCON", "TIT2", "TLEN",
                               "TPE1", "TPE2", "TPUB", "TRCK", "TYER"};
    string       ids3 [9] = '{"COM", "PIC", "TAL", "TCO", "TLE", "TP1", "TRK", "TT2", "TYE"};
    id = $urandom;
    case ($urandom_range(3))
      0: id[31:24] = "T";
      1: ;
      default: begin
        if (ver == 2) id = {ids3[$urandom_range(8)][0], ids3[$urandom_range(8)][1], 16'h0};
        else id = 32'h0;
      end
    endcase
    if (ver == 2 && $urandom_range(1)) begin
      n = $urandom_range(8);
      id = {ids3[n][0], ids3[n][1], ids3[n][2], 8'h0};
    end else if (ver != 2 && id == 32'h0) begin
      n = $urandom_range(10);
      id = {ids4[n][0], ids4[n][1], ids4[n][2], ids4[n][3]};
    end
    if (id[31:24] == 8'h00) id[31:24] = "X";
    n = $urandom_range(9);
    if ($urandom_range(15) == 0) n = 32'h7f;
    fl = 8'h00;
    if (ver == 3 && $urandom_range(9) == 0) fl = 8'($urandom_range(255));
    if (ver == 4) begin
      case ($urandom_range(5))
        0: fl = 8'h01;
        1: fl = 8'h02;
        2: fl = 8'h03;
        3: fl = 8'($urandom_range(255));
        default: fl = 8'h00;
      endcase
    end
    body.push_back(id[31:24]); body.push_back(id[23:16]); body.push_back(id[15:8]);
    if (ver == 2) begin
      body.push_back(8'h00); body.push_back(8'h00); body.push_back(8'(n));
    end else begin
      body.push_back(id[7:0]);
      body.push_back(8'h00); body.push_back(8'h00); body.push_back(8'h00);
      body.push_back(8'(n));
      body.push_back(8'h00); body.push_back(fl);
    end
    if (n == 32'h7f) n = 3;
    repeat (n) body.push_back(rand_data());
  endfunction

  // how: 0 clean, 1 bad magic, 2 size byte with top bit, 3 declared size off, 4 empty
  function automatic void gen_tag(int ver, logic [7:0] flg, int how);
    logic [7:0]  body[$];
    logic [27:0] sz;
    int          n, adj;
    in_item_t    it;
    if (ver == 3 && flg[6]) begin
      n = $urandom_range(5);
      body.push_back(8'h00); body.push_back(8'h00); body.push_back(8'h00);
      body.push_back(8'(n));
      repeat (n) body.push_back(8'($urandom_range(255)));
    end
    repeat ($urandom_range(1, 4)) add_frame(body, ver);
    repeat ($urandom_range(3)) body.push_back(8'h00);
    sz = 28'(body.size());
    if (how == 3) begin
      adj = $urandom_range(6);
      sz = (adj < 3 && sz > 28'(adj)) ? sz - 28'(adj) : sz + 28'(adj);
    end
    if (how == 4) sz = 0;
    it.tag_start = 1'b1;
    it.byte_in = (how == 1) ? 8'h4a : 8'h49;
    stim_q.push_back(it);
    it.tag_start = 1'b0;
    it.byte_in = 8'h44; stim_q.push_back(it);
    it.byte_in = 8'h33; stim_q.push_back(it);
    it.byte_in = 8'(ver); stim_q.push_back(it);
    it.byte_in = 8'($urandom_range(254)); stim_q.push_back(it);
    it.byte_in = flg; stim_q.push_back(it);
    it.byte_in = {1'b0, sz[27:21]}; stim_q.push_back(it);
    it.byte_in = {1'b0, sz[20:14]}; stim_q.push_back(it);
    it.byte_in = {1'b0, sz[13:7]}; stim_q.push_back(it);
    it.byte_in = {(how == 2), sz[6:0]}; stim_q.push_back(it);
    foreach (body[i]) begin
      it.byte_in = body[i];
      stim_q.push_back(it);
    end
    repeat ($urandom_range(2)) begin
      it.byte_in = 8'($urandom_range(255));
      stim_q.push_back(it);
    end
  endfunction

  function automatic void push_bytes(logic [7:0] bytes[$]);
    in_item_t it;
    foreach (bytes[i]) begin
      it.tag_start = (i == 0);
      it.byte_in = bytes[i];
      stim_q.push_back(it);
    end
  endfunction

  task automatic send_byte(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note_byte(it);
    n_bytes++;
  endtask

  task automatic drain_stim();
    while (stim_q.size() > 0) send_byte(stim_q.pop_front());
  endtask

  initial begin
    int       v, phase_no, base;
    in_item_t it;
    sb = new();
    sb.restart();
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cycles = 0;
    n_bytes = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each version, flag cases, bad magic/version/size, empty tag
    gen_tag(2, 8'h00, 0);
    gen_tag(3, 8'h00, 0);
    gen_tag(3, 8'h40, 0);
    gen_tag(4, 8'h80, 0);
    gen_tag(3, 8'h80, 0);
    gen_tag(4, 8'h10, 0);
    gen_tag(3, 8'h01, 0);
    gen_tag(2, 8'h40, 0);
    gen_tag(5, 8'h00, 0);
    gen_tag(1, 8'h00, 0);
    gen_tag(3, 8'h00, 1);
    gen_tag(4, 8'h00, 2);
    gen_tag(3, 8'h00, 4);
    gen_tag(4, 8'h00, 3);
    // unsync zero on the last byte of a text frame
    push_bytes('{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h0d,
                 "T", "I", "T", "2", 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00,
                 8'h03, 8'hff, 8'h00});
    // data-length flag on a 2-byte frame, then a text frame with only its encoding
    push_bytes('{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h19,
                 "T", "A", "L", "B", 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01,
                 8'h00, 8'h00, 8'h00, 8'h02,
                 "C", "O", "M", "M", 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01});
    drain_stim();

    // random: mostly well-formed tags, some broken, some noise
    base = n_bytes;
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (phase_no == 0) hold_req <= 1'b1;
      while (n_bytes < base + (phase_no + 1) * RANDOM_BYTES / 4) begin
        v = $urandom_range(19);
        if (v < 14) gen_tag($urandom_range(2, 4),
                            ($urandom_range(3) == 0) ? 8'h80 : 8'h00, 0);
        else if (v == 14) gen_tag(3, 8'h40 | (($urandom_range(1)) ? 8'h80 : 8'h00), 0);
        else if (v == 15) gen_tag($urandom_range(2, 4), 8'($urandom_range(255)), 3);
        else if (v == 16) gen_tag($urandom_range(0, 6), 8'($urandom_range(255)),
                                  $urandom_range(4));
        else begin
          repeat ($urandom_range(1, 12)) begin
            it.byte_in = 8'($urandom_range(255));
            it.tag_start = ($urandom_range(7) == 0);
            stim_q.push_back(it);
          end
        end
        drain_stim();
      end
    end
    in_valid <= 1'b0;

    while (sb.event_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d bytes of tags across four pacing modes, checked %0d events",
             n_bytes, sb.n_events);
    if (sb.mismatches == 0 && sb.event_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
